### sv/pps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int IDX_W     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int TIME_W    = 16;
    localparam int SUM_W     = 20;
    localparam int PRI_W     = 8;
    localparam int JOB_NUM_W = 5;
    localparam int STATUS_W  = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_LOADED   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RAN      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_IDLE     = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_length;
        logic [PRI_W-1:0]  priority_level;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [JOB_NUM_W-1:0] job_number;
        logic [TIME_W-1:0]    time_now;
        logic                 job_finished;
        logic [TIME_W-1:0]    completion_time;
        logic [TIME_W-1:0]    turnaround_time;
        logic [TIME_W-1:0]    waiting_time;
        logic [SUM_W-1:0]     total_turnaround;
        logic [SUM_W-1:0]     total_waiting;
        logic [JOB_NUM_W-1:0] finished_count;
        logic                 all_done;
    } rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRI_W-1:0]  prio;
        logic [TIME_W-1:0] remaining;
    } job_rec_t;

endpackage
`default_nettype wire

### sv/pps_job_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_job_table
// Job record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pps_job_table
    import pps_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire job_rec_t         wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output job_rec_t              rd_data
);

    job_rec_t mem [MAX_JOBS];
    job_rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### sv/preemptive_priority_scheduler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Preemptive priority scheduler over a table of MAX_JOBS jobs.
//
// Command channel (cmd_valid / cmd_stall / cmd): a beat with opcode load
// stores a job (arrival, burst, priority) in the next free entry; a beat
// with opcode tick runs the highest priority arrived job for one time unit.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per
// command, in command order.
// Sequence: a load goes from accept through the emit state to the response
// register. A tick scans the loaded entries with one comparator, one entry
// per cycle from the job memory read port, then updates the chosen entry.
// Throughput: one command at a time; cmd_stall is high while a command is
// in progress. A new command is taken while a response waits in the output
// register; if that register is still held by rsp_stall when the next
// response is ready, the block waits until it drains.
// Reset clears time, counters, totals and all done flags; the table holds
// no jobs. Job records need no reset.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top
    import pps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RDSEL = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic [CNT_W-1:0]    done_cnt_reg, done_cnt_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [SUM_W-1:0]    sum_tat_reg, sum_tat_next;
    logic [SUM_W-1:0]    sum_wt_reg, sum_wt_next;
    logic [MAX_JOBS-1:0] job_done_reg, job_done_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                found_reg, found_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [PRI_W-1:0]    best_pri_reg, best_pri_next;
    logic [TIME_W-1:0]   best_arr_reg, best_arr_next;
    logic                fin_reg, fin_next;
    logic [TIME_W-1:0]   tat_reg, tat_next;
    logic [TIME_W-1:0]   burst_reg, burst_next;
    logic [TIME_W-1:0]   wt_reg, wt_next;
    rsp_t                res_reg, res_next;
    rsp_t                rsp_reg, rsp_next;

    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    job_rec_t            mem_wr_data;
    logic [IDX_W-1:0]    mem_rd_addr;
    job_rec_t            mem_rd_data;

    pps_job_table u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        logic [TIME_W-1:0] time_inc;
        logic              eligible;
        logic              better;
        logic [TIME_W-1:0] rem_new;
        logic [SUM_W:0]    tat_sum;
        logic [SUM_W:0]    wt_sum;
        logic [CNT_W-1:0]  k;

        state_next    = state_reg;
        loaded_next   = loaded_reg;
        done_cnt_next = done_cnt_reg;
        time_next     = time_reg;
        sum_tat_next  = sum_tat_reg;
        sum_wt_next   = sum_wt_reg;
        job_done_next = job_done_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = cmp_vld_reg;
        found_next    = found_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_idx_next = best_idx_reg;
        best_pri_next = best_pri_reg;
        best_arr_next = best_arr_reg;
        fin_next      = fin_reg;
        tat_next      = tat_reg;
        burst_next    = burst_reg;
        wt_next       = wt_reg;
        res_next      = res_reg;
        rsp_next      = rsp_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = best_idx_reg;
        mem_wr_data = mem_rd_data;
        mem_rd_addr = best_idx_reg;

        time_inc = (time_reg == TIME_MAX) ? time_reg : time_reg + 1'b1;
        eligible = !job_done_reg[cmp_idx_reg] && (mem_rd_data.arrival <= time_reg);
        better   = !found_reg || (mem_rd_data.prio < best_pri_reg) ||
                   ((mem_rd_data.prio == best_pri_reg) &&
                    (mem_rd_data.arrival < best_arr_reg));
        rem_new  = mem_rd_data.remaining - 1'b1;
        tat_sum  = {1'b0, sum_tat_reg} + (SUM_W+1)'(tat_reg);
        wt_sum   = {1'b0, sum_wt_reg} + (SUM_W+1)'(wt_reg);
        k        = loaded_reg;

        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_next                  = '0;
                    res_next.time_now         = time_reg;
                    res_next.total_turnaround = sum_tat_reg;
                    res_next.total_waiting    = sum_wt_reg;
                    res_next.finished_count   = JOB_NUM_W'(32'(done_cnt_reg));
                    if (cmd.opcode == OP_LOAD)
                    begin
                        if ((cmd.burst_length == '0) || (loaded_reg == CNT_W'(MAX_JOBS)))
                        begin
                            res_next.status   = STAT_REJECTED;
                            res_next.all_done = (done_cnt_reg == loaded_reg);
                        end
                        else
                        begin
                            mem_wr_en             = 1'b1;
                            mem_wr_addr           = k[IDX_W-1:0];
                            mem_wr_data.arrival   = cmd.arrival_time;
                            mem_wr_data.burst     = cmd.burst_length;
                            mem_wr_data.prio      = cmd.priority_level;
                            mem_wr_data.remaining = cmd.burst_length;
                            job_done_next[k[IDX_W-1:0]] = 1'b0;
                            loaded_next           = loaded_reg + 1'b1;
                            res_next.status       = STAT_LOADED;
                            res_next.job_number   = JOB_NUM_W'(32'(loaded_reg) + 32'd1);
                            res_next.all_done     = 1'b0;
                        end
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        issue_next   = '0;
                        cmp_vld_next = 1'b0;
                        found_next   = 1'b0;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (cmp_vld_reg && eligible && better)
                begin
                    found_next    = 1'b1;
                    best_idx_next = cmp_idx_reg;
                    best_pri_next = mem_rd_data.prio;
                    best_arr_next = mem_rd_data.arrival;
                end
                if (issue_reg < loaded_reg)
                begin
                    mem_rd_addr  = issue_reg[IDX_W-1:0];
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                    cmp_vld_next = 1'b1;
                    issue_next   = issue_reg + 1'b1;
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg)
                    begin
                        if (found_reg)
                        begin
                            state_next = S_RDSEL;
                        end
                        else
                        begin
                            time_next                 = time_inc;
                            res_next                  = '0;
                            res_next.status           = STAT_IDLE;
                            res_next.time_now         = time_inc;
                            res_next.total_turnaround = sum_tat_reg;
                            res_next.total_waiting    = sum_wt_reg;
                            res_next.finished_count   = JOB_NUM_W'(32'(done_cnt_reg));
                            res_next.all_done         = (done_cnt_reg == loaded_reg);
                            state_next                = S_EMIT;
                        end
                    end
                end
            end
            S_RDSEL:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                mem_wr_en             = 1'b1;
                mem_wr_data.remaining = rem_new;
                fin_next              = (rem_new == '0);
                tat_next              = time_inc - mem_rd_data.arrival;
                burst_next            = mem_rd_data.burst;
                state_next            = S_WAIT;
            end
            S_WAIT:
            begin
                wt_next    = (tat_reg >= burst_reg) ? tat_reg - burst_reg : '0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                time_next           = time_inc;
                res_next            = '0;
                res_next.status     = STAT_RAN;
                res_next.job_number = JOB_NUM_W'(32'(best_idx_reg) + 32'd1);
                res_next.time_now   = time_inc;
                if (fin_reg)
                begin
                    sum_tat_next  = (tat_sum > {1'b0, SUM_MAX}) ? SUM_MAX : tat_sum[SUM_W-1:0];
                    sum_wt_next   = (wt_sum > {1'b0, SUM_MAX}) ? SUM_MAX : wt_sum[SUM_W-1:0];
                    job_done_next[best_idx_reg] = 1'b1;
                    done_cnt_next = done_cnt_reg + 1'b1;
                    res_next.job_finished    = 1'b1;
                    res_next.completion_time = time_inc;
                    res_next.turnaround_time = tat_reg;
                    res_next.waiting_time    = wt_reg;
                end
                res_next.total_turnaround = sum_tat_next;
                res_next.total_waiting    = sum_wt_next;
                res_next.finished_count   = JOB_NUM_W'(32'(done_cnt_next));
                res_next.all_done         = (done_cnt_next == loaded_reg);
                state_next                = S_EMIT;
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            done_cnt_reg  <= '0;
            time_reg      <= '0;
            sum_tat_reg   <= '0;
            sum_wt_reg    <= '0;
            job_done_reg  <= '0;
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            done_cnt_reg  <= done_cnt_next;
            time_reg      <= time_next;
            sum_tat_reg   <= sum_tat_next;
            sum_wt_reg    <= sum_wt_next;
            job_done_reg  <= job_done_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_pri_reg <= best_pri_next;
        best_arr_reg <= best_arr_next;
        fin_reg      <= fin_next;
        tat_reg      <= tat_next;
        burst_reg    <= burst_next;
        wt_reg       <= wt_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_done_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        done_cnt_reg <= loaded_reg)
        else $error("finished count exceeds loaded count");

    a_loaded_max: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CNT_W'(MAX_JOBS))
        else $error("loaded count beyond table size");

    a_sel_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> !job_done_reg[best_idx_reg])
        else $error("selected job already finished");

    a_rsp_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !$past(rsp_valid_reg && rsp_stall)) |->
            ($past(state_reg) == S_EMIT))
        else $error("response beat not from emit state");

    a_time_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        (time_reg != $past(time_reg)) |-> (time_reg == $past(time_reg) + 1'b1))
        else $error("time moved by more than one");

endmodule
`default_nettype wire
